>>> sv/pbpd_pkg.sv
// shared types and constants for the burst phase detector
package pbpd_pkg;

	localparam int ACC_W     = 48;
	localparam int PROD_W    = 35;
	localparam int AVG_W     = 22;
	localparam int VEC_W     = 23;
	localparam int SQ_W      = 46;
	localparam int MAG2_W    = 42;
	localparam int MAG_W     = 26;
	localparam int NRM_W     = 17;
	localparam int ROT_W     = 33;
	localparam int OUT_W     = 18;
	localparam int CFG_W     = 16;

	localparam int DIV_DVD_W = 48;
	localparam int DIV_DVS_W = 26;
	localparam int DIV_CNT_W = 6;

	localparam int SQRT_X_W   = 50;
	localparam int SQRT_R_W   = 25;
	localparam int SQRT_REM_W = 28;
	localparam int SQRT_CNT_W = 5;

	// configuration register indexes
	localparam logic [1:0] REG_ROT_COS   = 2'd0;
	localparam logic [1:0] REG_ROT_SIN   = 2'd1;
	localparam logic [1:0] REG_MIN_LEVEL = 2'd2;

	// divider operand selects
	localparam logic [2:0] SEL_PS = 3'd0;
	localparam logic [2:0] SEL_QS = 3'd1;
	localparam logic [2:0] SEL_PA = 3'd2;
	localparam logic [2:0] SEL_QA = 3'd3;
	localparam logic [2:0] SEL_NU = 3'd4;
	localparam logic [2:0] SEL_NV = 3'd5;

	typedef struct packed {
		logic       take;
		logic       div_start;
		logic       div_store;
		logic [2:0] div_sel;
		logic       clr;
		logic       vec_ld;
		logic       sq_ld;
		logic       cmp_ld;
		logic       sqrt_start;
		logic       mag_ld;
		logic       rot_ld;
		logic       out_ld;
	} pbpd_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic div_done;
		logic sqrt_busy;
		logic sqrt_done;
		logic out_full;
	} pbpd_sts_t;

endpackage

>>> sv/pal_burst_phase_detector_unit.sv
// top level of the pal colour burst phase and v-switch detector
// throughput: one burst sample beat per cycle while accumulating
// after the last sample the result beat comes from six divisions on the shared divider,
//   a square root and the flush, vector, square, compare, rotate and output steps
// the result beat waits in an output register; the next burst may start meanwhile
// reset: arst_n asynchronous, clears control, accumulators and config to defaults
module pal_burst_phase_detector_unit #(
	parameter int MAX_BURST_SAMPLES = 256,
	parameter int SAMPLE_BITS       = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [15:0]              cfg_wdata,
	// sample beats
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [15:0]              cur_sample,
	input  logic [15:0]              above1_sample,
	input  logic [15:0]              below1_sample,
	input  logic [15:0]              above2_sample,
	input  logic [15:0]              below2_sample,
	input  logic signed [15:0]       ref_sine,
	input  logic signed [15:0]       ref_cosine,
	input  logic                     last_sample,
	// result beats
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [17:0]       burst_p,
	output logic signed [17:0]       burst_q,
	output logic                     v_switch,
	output logic                     burst_weak
);

	pbpd_pkg::pbpd_cmd_t cmd;
	pbpd_pkg::pbpd_sts_t sts;

	// controller: accepts sample beats, then walks the end-of-burst steps
	pbpd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.in_ready    (in_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	// datapath: product detection, averaging, normalize and rotate
	pbpd_dp #(
		.MAX_BURST_SAMPLES (MAX_BURST_SAMPLES),
		.SAMPLE_BITS       (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.cur_sample    (cur_sample),
		.above1_sample (above1_sample),
		.below1_sample (below1_sample),
		.above2_sample (above2_sample),
		.below2_sample (below2_sample),
		.ref_sine      (ref_sine),
		.ref_cosine    (ref_cosine),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.burst_p       (burst_p),
		.burst_q       (burst_q),
		.v_switch      (v_switch),
		.burst_weak    (burst_weak)
	);

	// a last sample beat ends the accumulation phase
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> !in_ready)
		else $error("input still open after last sample beat");

	// a new result appears exactly when the block returns to accumulation
	a_result_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result issued without reopening input");

	// no iterative unit may run while samples are accepted
	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!sts.div_busy && !sts.sqrt_busy))
		else $error("divider or square root busy during accumulation");

endmodule

>>> sv/pbpd_div.sv
// restoring divider, one quotient bit per cycle
module pbpd_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pbpd_pkg::DIV_DVD_W-1:0]     dividend,
	input  logic [pbpd_pkg::DIV_DVS_W-1:0]     divisor,
	output logic [pbpd_pkg::DIV_DVD_W-1:0]     quotient,
	output logic                               busy,
	output logic                               done
);

	localparam int DW = pbpd_pkg::DIV_DVD_W;
	localparam int SW = pbpd_pkg::DIV_DVS_W;
	localparam int CW = pbpd_pkg::DIV_CNT_W;

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] dvd_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [SW:0]   shifted;
	logic [SW:0]   diff;
	logic          ge;

	assign shifted = {rem_q, dvd_q[DW-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[SW-1:0] : shifted[SW-1:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	assign quotient = dvd_q;
	assign busy     = (cnt_q != '0);
	assign done     = done_q;

endmodule

>>> sv/pbpd_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module pbpd_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pbpd_pkg::SQRT_X_W-1:0]     radicand,
	output logic [pbpd_pkg::SQRT_R_W-1:0]     root,
	output logic                              busy,
	output logic                              done
);

	localparam int XW = pbpd_pkg::SQRT_X_W;
	localparam int RW = pbpd_pkg::SQRT_R_W;
	localparam int MW = pbpd_pkg::SQRT_REM_W;
	localparam int CW = pbpd_pkg::SQRT_CNT_W;

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [XW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [MW-1:0] rem_q;
	logic [MW-1:0] rem2;
	logic [MW-1:0] trial;
	logic          ge;

	assign rem2  = {rem_q[MW-3:0], x_q[XW-1:XW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = rem2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(RW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= {x_q[XW-3:0], 2'b00};
			rem_q  <= ge ? rem2 - trial : rem2;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign busy = (cnt_q != '0);
	assign done = done_q;

endmodule

>>> sv/pbpd_dp.sv
// datapath: accumulators, averages, burst vector, normalize, rotate
module pbpd_dp #(
	parameter int MAX_BURST_SAMPLES = 256,
	parameter int SAMPLE_BITS       = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pbpd_pkg::pbpd_cmd_t             cmd,
	output pbpd_pkg::pbpd_sts_t             sts,
	input  logic                            cfg_wr_en,
	input  logic [1:0]                      cfg_index,
	input  logic [pbpd_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [15:0]                     cur_sample,
	input  logic [15:0]                     above1_sample,
	input  logic [15:0]                     below1_sample,
	input  logic [15:0]                     above2_sample,
	input  logic [15:0]                     below2_sample,
	input  logic signed [15:0]              ref_sine,
	input  logic signed [15:0]              ref_cosine,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic signed [pbpd_pkg::OUT_W-1:0] burst_p,
	output logic signed [pbpd_pkg::OUT_W-1:0] burst_q,
	output logic                            v_switch,
	output logic                            burst_weak
);

	localparam int CNT_W = $clog2(MAX_BURST_SAMPLES + 1);
	localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam int ACC_W  = pbpd_pkg::ACC_W;
	localparam int PROD_W = pbpd_pkg::PROD_W;
	localparam int AVG_W  = pbpd_pkg::AVG_W;
	localparam int VEC_W  = pbpd_pkg::VEC_W;
	localparam int SQ_W   = pbpd_pkg::SQ_W;
	localparam int MAG2_W = pbpd_pkg::MAG2_W;
	localparam int MAG_W  = pbpd_pkg::MAG_W;
	localparam int NRM_W  = pbpd_pkg::NRM_W;
	localparam int ROT_W  = pbpd_pkg::ROT_W;
	localparam int OUT_W  = pbpd_pkg::OUT_W;
	localparam int DW     = pbpd_pkg::DIV_DVD_W;
	localparam int SW     = pbpd_pkg::DIV_DVS_W;

	function automatic logic signed [OUT_W-1:0] rnd_sat(input logic signed [ROT_W:0] x);
		logic [ROT_W:0]        mag;
		logic [ROT_W-11:0]     r;
		logic signed [ROT_W-10:0] s;
		mag = x[ROT_W] ? (ROT_W+1)'(-x) : (ROT_W+1)'(x);
		r   = (ROT_W-10)'((mag + (ROT_W+1)'(2048)) >> 12);
		s   = x[ROT_W] ? -$signed({1'b0, r}) : $signed({1'b0, r});
		if (s > (ROT_W-9)'(131071)) begin
			rnd_sat = OUT_W'(131071);
		end else if (s < -(ROT_W-9)'(131072)) begin
			rnd_sat = OUT_W'(-131072);
		end else begin
			rnd_sat = OUT_W'(s);
		end
	endfunction

	// configuration
	logic signed [15:0] rot_cos_q, rot_sin_q;
	logic        [15:0] min_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_cos_q   <= 16'sd4096;
			rot_sin_q   <= '0;
			min_level_q <= 16'd1016;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pbpd_pkg::REG_ROT_COS:   rot_cos_q   <= cfg_wdata;
				pbpd_pkg::REG_ROT_SIN:   rot_sin_q   <= cfg_wdata;
				pbpd_pkg::REG_MIN_LEVEL: min_level_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// product detection
	logic [15:0] cur_m, a1_m, b1_m, a2_m, b2_m;
	logic signed [18:0] ds, da;
	logic [CNT_W-1:0] cnt_q;
	logic             acc_en;
	logic             vld_s1;
	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [ACC_W-1:0]  acc_q [4];

	assign cur_m = cur_sample & SMASK;
	assign a1_m  = above1_sample & SMASK;
	assign b1_m  = below1_sample & SMASK;
	assign a2_m  = above2_sample & SMASK;
	assign b2_m  = below2_sample & SMASK;
	assign ds = $signed({2'b00, cur_m, 1'b0}) - $signed({3'b000, a2_m})
		- $signed({3'b000, b2_m});
	assign da = $signed({2'b00, b1_m, 1'b0}) - $signed({2'b00, a1_m, 1'b0});
	assign acc_en = cnt_q < CNT_W'(MAX_BURST_SAMPLES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.take && acc_en;
			if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.take && acc_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_s1[0] <= ds * ref_sine;
			prod_s1[1] <= ds * ref_cosine;
			prod_s1[2] <= da * ref_sine;
			prod_s1[3] <= da * ref_cosine;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
		end else if (cmd.clr) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
		end else if (vld_s1) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= acc_q[i] + ACC_W'(prod_s1[i]);
		end
	end

	// shared divider operands
	logic signed [AVG_W-1:0] avg_q [4];
	logic signed [VEC_W-1:0] dp_q, dq_q, u_q, v_q;
	logic [MAG_W-1:0]        mag_q;
	logic signed [NRM_W-1:0] nrm_q [2];
	logic [CNT_W-1:0]        cnt_eff;
	logic signed [ACC_W-1:0] sel_acc;
	logic signed [VEC_W-1:0] sel_vec;
	logic [VEC_W-1:0]        vec_mag;
	logic                    div_neg;
	logic                    dsign_q;
	logic [DW-1:0]           dvd;
	logic [SW-1:0]           dvs;
	logic [DW-1:0]           quo;
	logic                    div_busy, div_done;

	assign cnt_eff = (cnt_q == '0) ? CNT_W'(1) : cnt_q;
	assign sel_acc = acc_q[cmd.div_sel[1:0]];
	assign sel_vec = cmd.div_sel[0] ? v_q : u_q;
	assign vec_mag = sel_vec[VEC_W-1] ? VEC_W'(-sel_vec) : VEC_W'(sel_vec);

	always_comb begin
		if (cmd.div_sel[2]) begin
			div_neg = sel_vec[VEC_W-1];
			dvd     = (DW'(vec_mag) << 18) + DW'(mag_q >> 1);
			dvs     = SW'(mag_q);
		end else begin
			div_neg = sel_acc[ACC_W-1];
			dvd     = (sel_acc[ACC_W-1] ? DW'(-sel_acc) : DW'(sel_acc))
				+ (DW'(cnt_eff) << 12);
			dvs     = SW'(cnt_eff) << 13;
		end
	end

	pbpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.busy     (div_busy),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dsign_q <= div_neg;
		end
		if (cmd.div_store) begin
			if (cmd.div_sel[2]) begin
				nrm_q[cmd.div_sel[0]] <= dsign_q ? -NRM_W'(quo) : NRM_W'(quo);
			end else begin
				avg_q[cmd.div_sel[1:0]] <= dsign_q ? -AVG_W'(quo) : AVG_W'(quo);
			end
		end
	end

	// burst vector, squares and compares
	logic signed [VEC_W-1:0] ps_x, qs_x, pa_x, qa_x;
	logic signed [SQ_W-1:0]  sdp_q, sdq_q, sps_q, sqs_q, su_q, sv_q;
	logic [20:0]             fl;
	logic [15:0]             lvl_eff;
	logic [41:0]             flsq_q;
	logic [MAG2_W-1:0]       mag2_q;
	logic                    vsw_q, weak_q;
	logic signed [SQ_W+1:0]  lhs, rhs;
	logic signed [SQ_W:0]    mag2_full;

	assign ps_x = VEC_W'(avg_q[0]);
	assign qs_x = VEC_W'(avg_q[1]);
	assign pa_x = VEC_W'(avg_q[2]);
	assign qa_x = VEC_W'(avg_q[3]);
	assign lvl_eff = (min_level_q == '0) ? 16'd1 : min_level_q;
	assign fl = {lvl_eff, 5'b00000};
	assign lhs = (SQ_W+2)'(sdp_q) + (SQ_W+2)'(sdq_q);
	assign rhs = ((SQ_W+2)'(sps_q) + (SQ_W+2)'(sqs_q)) <<< 1;
	assign mag2_full = (SQ_W+1)'(su_q) + (SQ_W+1)'(sv_q);

	always_ff @(posedge clk) begin
		if (cmd.vec_ld) begin
			dp_q <= ps_x - pa_x;
			dq_q <= qs_x - qa_x;
			u_q  <= ps_x - qa_x;
			v_q  <= qs_x + pa_x;
		end
		if (cmd.sq_ld) begin
			sdp_q  <= dp_q * dp_q;
			sdq_q  <= dq_q * dq_q;
			sps_q  <= ps_x * ps_x;
			sqs_q  <= qs_x * qs_x;
			su_q   <= u_q * u_q;
			sv_q   <= v_q * v_q;
			flsq_q <= fl * fl;
		end
		if (cmd.cmp_ld) begin
			vsw_q  <= lhs < rhs;
			weak_q <= mag2_full < $signed({5'b00000, flsq_q});
			mag2_q <= MAG2_W'(mag2_full);
		end
	end

	// magnitude
	logic [pbpd_pkg::SQRT_R_W-1:0] root;
	logic                          sqrt_busy, sqrt_done;

	pbpd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand ({mag2_q, 8'h00}),
		.root     (root),
		.busy     (sqrt_busy),
		.done     (sqrt_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.mag_ld) begin
			mag_q <= weak_q ? MAG_W'({lvl_eff, 9'h000}) : MAG_W'(root);
		end
	end

	// rotation and output register
	logic signed [ROT_W-1:0] m_urc_s1, m_vrs_s1, m_urs_s1, m_vrc_s1;
	logic signed [ROT_W:0]   p_full, q_full;
	logic                    out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.rot_ld) begin
			m_urc_s1 <= nrm_q[0] * rot_cos_q;
			m_vrs_s1 <= nrm_q[1] * rot_sin_q;
			m_urs_s1 <= nrm_q[0] * rot_sin_q;
			m_vrc_s1 <= nrm_q[1] * rot_cos_q;
		end
	end

	assign p_full = (ROT_W+1)'(m_urc_s1) - (ROT_W+1)'(m_vrs_s1);
	assign q_full = (ROT_W+1)'(m_urs_s1) + (ROT_W+1)'(m_vrc_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			burst_p    <= rnd_sat(p_full);
			burst_q    <= rnd_sat(q_full);
			v_switch   <= vsw_q;
			burst_weak <= weak_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.div_busy  = div_busy;
	assign sts.div_done  = div_done;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.sqrt_done = sqrt_done;
	assign sts.out_full  = out_valid_q && !out_ready;

endmodule

>>> sv/pbpd_ctrl.sv
// controller: sequences accumulation and end-of-burst processing
module pbpd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 last_sample,
	output logic                 in_ready,
	input  pbpd_pkg::pbpd_sts_t  sts,
	output pbpd_pkg::pbpd_cmd_t  cmd
);

	localparam logic [3:0] S_ACC   = 4'd0;
	localparam logic [3:0] S_FLUSH = 4'd1;
	localparam logic [3:0] S_DGO   = 4'd2;
	localparam logic [3:0] S_DWT   = 4'd3;
	localparam logic [3:0] S_VEC   = 4'd4;
	localparam logic [3:0] S_SQR   = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_RGO   = 4'd7;
	localparam logic [3:0] S_RWT   = 4'd8;
	localparam logic [3:0] S_NGO   = 4'd9;
	localparam logic [3:0] S_NWT   = 4'd10;
	localparam logic [3:0] S_ROT   = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [2:0] sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.div_sel = sel_q;
		in_ready = 1'b0;
		case (state_q)
			S_ACC: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && last_sample) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				sel_d   = pbpd_pkg::SEL_PS;
				state_d = S_DGO;
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_d = S_DWT;
			end
			S_DWT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == pbpd_pkg::SEL_QA) begin
						state_d = S_VEC;
					end else begin
						sel_d   = sel_q + 3'd1;
						state_d = S_DGO;
					end
				end
			end
			S_VEC: begin
				cmd.vec_ld = 1'b1;
				cmd.clr    = 1'b1;
				state_d    = S_SQR;
			end
			S_SQR: begin
				cmd.sq_ld = 1'b1;
				state_d   = S_CMP;
			end
			S_CMP: begin
				cmd.cmp_ld = 1'b1;
				state_d    = S_RGO;
			end
			S_RGO: begin
				cmd.sqrt_start = 1'b1;
				state_d = S_RWT;
			end
			S_RWT: begin
				if (sts.sqrt_done) begin
					cmd.mag_ld = 1'b1;
					sel_d   = pbpd_pkg::SEL_NU;
					state_d = S_NGO;
				end
			end
			S_NGO: begin
				cmd.div_start = 1'b1;
				state_d = S_NWT;
			end
			S_NWT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == pbpd_pkg::SEL_NV) begin
						state_d = S_ROT;
					end else begin
						sel_d   = pbpd_pkg::SEL_NV;
						state_d = S_NGO;
					end
				end
			end
			S_ROT: begin
				cmd.rot_ld = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_full) begin
					cmd.out_ld = 1'b1;
					state_d    = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			sel_q   <= pbpd_pkg::SEL_PS;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

endmodule

>>> test/pal_burst_phase_detector_unit_tb.sv
// testbench for the pal burst phase and v-switch detector, self-checking against a predictor
module pal_burst_phase_detector_unit_tb;

	localparam int BURST_MAX   = 256;   // accumulation stops at this many samples
	localparam int DRAIN_WAIT  = 400;   // settling wait once all results are back
	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_LEN    = 2500;  // long receiver hold-off for the pressure test

	typedef struct {
		logic [15:0]        cur, a1, b1, a2, b2;
		logic signed [15:0] sn, cs;
		logic               last;
	} sample_beat_t;

	typedef struct {
		logic signed [17:0] p, q;
		logic               vsw, floored;
	} burst_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = pbpd_pkg::REG_ROT_COS;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] cur_sample = '0, above1_sample = '0, below1_sample = '0;
	logic [15:0] above2_sample = '0, below2_sample = '0;
	logic signed [15:0] ref_sine = '0, ref_cosine = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [17:0] burst_p, burst_q;
	logic v_switch, burst_weak;

	pal_burst_phase_detector_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.cur_sample(cur_sample), .above1_sample(above1_sample),
		.below1_sample(below1_sample), .above2_sample(above2_sample),
		.below2_sample(below2_sample), .ref_sine(ref_sine), .ref_cosine(ref_cosine),
		.last_sample(last_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.burst_p(burst_p), .burst_q(burst_q), .v_switch(v_switch), .burst_weak(burst_weak)
	);

	always #6 clk = ~clk;

	// shadow of the configuration and the accumulators
	logic [15:0] gain_cos = 16'd4096, gain_sin = 16'd0, floor_level = 16'd1016;
	longint acc_p_same, acc_q_same, acc_p_adj, acc_q_adj;
	int     acc_count;

	burst_result_t expected_bursts[$];
	int  mismatches = 0;
	int  beats_sent = 0;
	int  bursts_checked = 0;
	int  weak_seen = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;       // no idling on either side when set
	bit  hold_req = 1'b0;    // asks the receiver for one long hold-off

	function automatic longint round_div(longint num, longint den);
		longint m, q;
		m = num < 0 ? -num : num;
		q = (m + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint sat18(longint v);
		if (v > 131071) return 131071;
		if (v < -131072) return -131072;
		return v;
	endfunction

	// fold one accepted sample into the accumulators below the burst limit; on the last sample queue the result
	task automatic absorb_sample(sample_beat_t s);
		longint ds, da, sn, cs, den, ps, qs, pa, qa, dp, dq, u, v, fl, nu, nv, rc, rs;
		longint unsigned mag2, mag;
		burst_result_t r;
		sn = longint'(s.sn);
		cs = longint'(s.cs);
		if (acc_count < BURST_MAX) begin
			ds = 2 * longint'(s.cur) - longint'(s.a2) - longint'(s.b2);
			da = 2 * (longint'(s.b1) - longint'(s.a1));
			acc_p_same += ds * sn;
			acc_q_same += ds * cs;
			acc_p_adj  += da * sn;
			acc_q_adj  += da * cs;
			acc_count++;
		end
		if (!s.last) return;
		den = longint'(acc_count == 0 ? 1 : acc_count) << 13;
		ps = round_div(acc_p_same, den);
		qs = round_div(acc_q_same, den);
		pa = round_div(acc_p_adj, den);
		qa = round_div(acc_q_adj, den);
		dp = ps - pa;
		dq = qs - qa;
		r.vsw = (dp * dp + dq * dq) < 2 * (ps * ps + qs * qs);
		u = ps - qa;
		v = qs + pa;
		mag2 = u * u + v * v;
		// a floor of zero behaves as one
		fl = longint'(floor_level == 0 ? 16'd1 : floor_level) << 5;
		r.floored = mag2 < fl * fl;
		mag = r.floored ? (fl << 4) : int_sqrt(mag2 << 8);
		if (mag == 0) mag = 1;
		nu = round_div(u * 262144, mag);
		nv = round_div(v * 262144, mag);
		rc = longint'($signed(gain_cos));
		rs = longint'($signed(gain_sin));
		r.p = sat18(round_div(nu * rc - nv * rs, 4096));
		r.q = sat18(round_div(nu * rs + nv * rc, 4096));
		expected_bursts.push_back(r);
		acc_p_same = 0; acc_q_same = 0; acc_p_adj = 0; acc_q_adj = 0;
		acc_count = 0;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		mismatches++;
	endtask

	// offer one sample beat, hold it until taken, then maybe idle a little
	task automatic send_sample(sample_beat_t s);
		@(negedge clk);
		in_valid <= 1'b1;
		cur_sample <= s.cur; above1_sample <= s.a1; below1_sample <= s.b1;
		above2_sample <= s.a2; below2_sample <= s.b2;
		ref_sine <= s.sn; ref_cosine <= s.cs; last_sample <= s.last;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		absorb_sample(s);
		beats_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			pbpd_pkg::REG_ROT_COS:   gain_cos = val;
			pbpd_pkg::REG_ROT_SIN:   gain_sin = val;
			pbpd_pkg::REG_MIN_LEVEL: floor_level = val;
			default: ;
		endcase
	endtask

	// stop offering, all results back, then let the datapath settle before touching registers
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bursts.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// a plausible burst sample: carrier on the current line and neighbors, plus dc
	function automatic sample_beat_t burst_like(int idx, real amp, real theta, bit last);
		sample_beat_t s;
		real ph;
		ph = idx * 1.5707963 + 0.3;
		s.cur = 16'(32768 + int'(amp * $sin(ph + theta)));
		s.a2  = 16'(32768 - int'(amp * $sin(ph + theta)));
		s.b2  = 16'(32768 - int'(amp * $sin(ph + theta)));
		s.a1  = 16'(32768 + int'(amp * $cos(ph + theta)));
		s.b1  = 16'(32768 - int'(amp * $cos(ph + theta)));
		s.sn  = 16'(int'(32767.0 * $sin(ph)));
		s.cs  = 16'(int'(32767.0 * $cos(ph)));
		s.last = last;
		return s;
	endfunction

	function automatic sample_beat_t noise_sample(bit last);
		sample_beat_t s;
		s.cur = 16'($urandom); s.a1 = 16'($urandom); s.b1 = 16'($urandom);
		s.a2 = 16'($urandom); s.b2 = 16'($urandom);
		s.sn = 16'($urandom); s.cs = 16'($urandom);
		s.last = last;
		return s;
	endfunction

	// one burst of n samples; mostly carrier-like, sometimes pure noise
	task automatic send_burst(int n);
		real amp, theta;
		bit noisy;
		amp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 30000);
		theta = $urandom_range(0, 628) / 100.0;
		noisy = $urandom_range(0, 4) == 0;
		for (int i = 0; i < n; i++) begin
			if (noisy || $urandom_range(0, 19) == 0)
				send_sample(noise_sample(i == n - 1));
			else
				send_sample(burst_like(i, amp, theta, i == n - 1));
		end
	endtask

	function automatic int burst_len();
		if ($urandom_range(0, 39) == 0) return $urandom_range(250, 280);
		return $urandom_range(1, 24);
	endfunction

	// result checker
	always @(posedge clk) begin
		burst_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bursts.size() == 0) begin
				report_mismatch("unexpected result beat, burst_p", burst_p, 0);
			end else begin
				e = expected_bursts.pop_front();
				if (burst_p !== e.p) report_mismatch("burst_p", burst_p, e.p);
				if (burst_q !== e.q) report_mismatch("burst_q", burst_q, e.q);
				if (v_switch !== e.vsw) report_mismatch("v_switch", v_switch, e.vsw);
				if (burst_weak !== e.floored)
					report_mismatch("burst_weak", burst_weak, e.floored);
				bursts_checked++;
				if (e.floored) weak_seen++;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off when asked
	initial begin
		int stall_left, hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// default registers: single-sample burst, flat and extreme bursts, normal and tiny bursts
	task automatic test_defaults();
		sample_beat_t s;
		send_sample(burst_like(0, 20000.0, 0.5, 1'b1));
		// all zero: zero vector, floored
		s = '{cur: 16'h0, a1: 16'h0, b1: 16'h0, a2: 16'h0, b2: 16'h0,
			sn: 16'sh0, cs: 16'sh0, last: 1'b1};
		send_sample(s);
		// extreme samples against the most negative carrier
		s = '{cur: 16'hffff, a1: 16'h0, b1: 16'hffff, a2: 16'h0, b2: 16'h0,
			sn: -16'sd32768, cs: 16'sd32767, last: 1'b0};
		send_sample(s);
		s.last = 1'b1;
		s.cs = -16'sd32768;
		send_sample(s);
		for (int i = 0; i < 8; i++) send_sample(burst_like(i, 25000.0, 1.2, i == 7));
		// tiny burst: weak with the default floor
		for (int i = 0; i < 4; i++) send_sample(burst_like(i, 30.0, 2.0, i == 3));
		wait_drained();
	endtask

	// a burst longer than the accumulator limit, last sample included past it
	task automatic test_long_burst();
		for (int i = 0; i < BURST_MAX + 20; i++)
			send_sample(burst_like(i, 15000.0, 0.8, i == BURST_MAX + 19));
		wait_drained();
	endtask

	// register extremes: saturating gains, zero floor, maximum floor, floor of one
	task automatic test_register_extremes();
		write_reg(pbpd_pkg::REG_ROT_COS, 16'h7fff);
		write_reg(pbpd_pkg::REG_ROT_SIN, 16'h8000);
		write_reg(pbpd_pkg::REG_MIN_LEVEL, 16'd0);
		for (int i = 0; i < 6; i++) send_sample(burst_like(i, 28000.0, 0.2, i == 5));
		send_sample(noise_sample(1'b1));
		wait_drained();
		write_reg(pbpd_pkg::REG_ROT_COS, 16'h8000);
		write_reg(pbpd_pkg::REG_ROT_SIN, 16'h7fff);
		write_reg(pbpd_pkg::REG_MIN_LEVEL, 16'hffff);
		for (int i = 0; i < 5; i++) send_sample(burst_like(i, 30000.0, 3.5, i == 4));
		wait_drained();
		write_reg(pbpd_pkg::REG_MIN_LEVEL, 16'd1);
		for (int i = 0; i < 3; i++) send_sample(burst_like(i, 2.0, 0.0, i == 2));
		wait_drained();
	endtask

	// random phases with fresh registers between them; one phase holds the output long
	task automatic test_random_bursts();
		for (int phase = 0; phase < 8; phase++) begin
			write_reg(pbpd_pkg::REG_ROT_COS, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 8192) - 4096));
			write_reg(pbpd_pkg::REG_ROT_SIN, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 8192) - 4096));
			write_reg(pbpd_pkg::REG_MIN_LEVEL, ($urandom_range(0, 3) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 2000)));
			if (phase == 3) hold_req = 1'b1;
			repeat (12) send_burst(burst_len());
			while (beats_sent < 200 * (phase + 1) + 300) send_burst(burst_len());
			wait_drained();
		end
	endtask

	// closing stretch at full rate on both sides
	task automatic test_full_rate();
		quiet = 1'b1;
		write_reg(pbpd_pkg::REG_ROT_COS, 16'd4096);
		write_reg(pbpd_pkg::REG_ROT_SIN, 16'd2048);
		write_reg(pbpd_pkg::REG_MIN_LEVEL, 16'd500);
		repeat (20) send_burst($urandom_range(4, 16));
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		acc_p_same = 0; acc_q_same = 0; acc_p_adj = 0; acc_q_adj = 0;
		acc_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults();
		test_long_burst();
		test_register_extremes();
		test_random_bursts();
		test_full_rate();
		$display("covered %0d sample beats and %0d burst results (%0d floored)",
			beats_sent, bursts_checked, weak_seen);
		$display("register extremes, overlong bursts and a long output hold-off included");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
